// ===== design/q2r_pkg.sv =====
// shared widths, lane data type and identity constant for the quaternion to matrix block
package q2r_pkg;

  localparam int LANES   = 9;
  localparam int PROD_W  = 64;
  localparam int DEN_W   = 65;
  localparam int REM_W   = 66;
  localparam int QUO_W   = 32;
  localparam int OUT_W   = 32;
  localparam int STEPS   = 32;
  localparam logic [OUT_W-1:0] ONE_Q230 = 32'h4000_0000;

  typedef struct packed {
    logic [LANES-1:0][REM_W-1:0] rem;
    logic [LANES-1:0][QUO_W-1:0] quo;
    logic [LANES-1:0]            neg;
    logic [DEN_W-1:0]            den;
    logic                        zero;
  } div_t;

endpackage

// ===== design/q2r_front.sv =====
// products, norm and numerator magnitudes ahead of the divider chain
module q2r_front import q2r_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_in,
  output logic               ready_out,
  input  logic signed [31:0] qw,
  input  logic signed [31:0] qx,
  input  logic signed [31:0] qy,
  input  logic signed [31:0] qz,
  output logic               valid_out,
  input  logic               ready_in,
  output div_t               data_out
);

  logic signed [PROD_W-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic va_r, vb_r;
  logic adv_a, adv_b;
  div_t data_r, data_nxt;

  logic signed [REM_W-1:0] e_ww, e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
  logic signed [REM_W-1:0] num [LANES];

  assign adv_b     = !vb_r || ready_in;
  assign adv_a     = !va_r || adv_b;
  assign ready_out = adv_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (adv_a) va_r <= valid_in;
      if (adv_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && valid_in) begin
      ww_r <= qw * qw;
      xx_r <= qx * qx;
      yy_r <= qy * qy;
      zz_r <= qz * qz;
      xy_r <= qx * qy;
      xz_r <= qx * qz;
      yz_r <= qy * qz;
      wx_r <= qw * qx;
      wy_r <= qw * qy;
      wz_r <= qw * qz;
    end
    if (adv_b && va_r) data_r <= data_nxt;
  end

  assign e_ww = {{2{ww_r[PROD_W-1]}}, ww_r};
  assign e_xx = {{2{xx_r[PROD_W-1]}}, xx_r};
  assign e_yy = {{2{yy_r[PROD_W-1]}}, yy_r};
  assign e_zz = {{2{zz_r[PROD_W-1]}}, zz_r};
  assign e_xy = {{2{xy_r[PROD_W-1]}}, xy_r};
  assign e_xz = {{2{xz_r[PROD_W-1]}}, xz_r};
  assign e_yz = {{2{yz_r[PROD_W-1]}}, yz_r};
  assign e_wx = {{2{wx_r[PROD_W-1]}}, wx_r};
  assign e_wy = {{2{wy_r[PROD_W-1]}}, wy_r};
  assign e_wz = {{2{wz_r[PROD_W-1]}}, wz_r};

  always_comb begin
    num[0] = (e_ww + e_xx) - (e_yy + e_zz);
    num[1] = (e_xy - e_wz) <<< 1;
    num[2] = (e_xz + e_wy) <<< 1;
    num[3] = (e_xy + e_wz) <<< 1;
    num[4] = (e_ww + e_yy) - (e_xx + e_zz);
    num[5] = (e_yz - e_wx) <<< 1;
    num[6] = (e_xz - e_wy) <<< 1;
    num[7] = (e_yz + e_wx) <<< 1;
    num[8] = (e_ww + e_zz) - (e_xx + e_yy);
    data_nxt.den = DEN_W'(e_ww + e_xx) + DEN_W'(e_yy + e_zz);
    data_nxt.zero = (data_nxt.den == '0);
    for (int i = 0; i < LANES; i++) begin
      data_nxt.neg[i] = num[i][REM_W-1];
      data_nxt.rem[i] = num[i][REM_W-1] ? -num[i] : num[i];
      data_nxt.quo[i] = '0;
    end
  end

  assign valid_out = vb_r;
  assign data_out  = data_r;

endmodule

// ===== design/q2r_div_cell.sv =====
// one restoring division step for all nine lanes
module q2r_div_cell import q2r_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic shift_en,
  input  logic valid_in,
  output logic ready_out,
  input  div_t data_in,
  output logic valid_out,
  input  logic ready_in,
  output div_t data_out
);

  logic v_r;
  logic adv;
  div_t data_r, data_nxt;
  logic [REM_W-1:0] r_sh [LANES];
  logic             ge   [LANES];

  assign adv       = !v_r || ready_in;
  assign ready_out = adv;

  always_comb begin
    data_nxt = data_in;
    for (int i = 0; i < LANES; i++) begin
      r_sh[i] = shift_en ? {data_in.rem[i][REM_W-2:0], 1'b0} : data_in.rem[i];
      ge[i]   = r_sh[i] >= {1'b0, data_in.den};
      data_nxt.rem[i] = ge[i] ? r_sh[i] - {1'b0, data_in.den} : r_sh[i];
      data_nxt.quo[i] = {data_in.quo[i][QUO_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (adv) v_r <= valid_in;
  end

  always_ff @(posedge clk) begin
    if (adv && valid_in) data_r <= data_nxt;
  end

  assign valid_out = v_r;
  assign data_out  = data_r;

endmodule

// ===== design/q2r_round.sv =====
// rounding, sign and zero-norm override into the output register
module q2r_round import q2r_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_in,
  output logic                    ready_out,
  input  div_t                    data_in,
  output logic                    valid_out,
  input  logic                    ready_in,
  output logic [LANES-1:0][OUT_W-1:0] mat,
  output logic                    zero_norm
);

  logic v_r;
  logic adv;
  logic [LANES-1:0][OUT_W-1:0] mat_r, mat_nxt;
  logic zero_r;
  logic [QUO_W:0]   sum   [LANES];
  logic [OUT_W-1:0] mag   [LANES];

  assign adv       = !v_r || ready_in;
  assign ready_out = adv;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sum[i] = {1'b0, data_in.quo[i]} + (QUO_W+1)'(1);
      mag[i] = sum[i][QUO_W:1];
      if (data_in.zero) mat_nxt[i] = (i % 4 == 0) ? ONE_Q230 : '0;
      else mat_nxt[i] = data_in.neg[i] ? -mag[i] : mag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (adv) v_r <= valid_in;
  end

  always_ff @(posedge clk) begin
    if (adv && valid_in) begin
      mat_r  <= mat_nxt;
      zero_r <= data_in.zero;
    end
  end

  assign valid_out = v_r;
  assign mat       = mat_r;
  assign zero_norm = zero_r;

endmodule

// ===== design/quat_to_rotation_matrix.sv =====
// quaternion to 3x3 rotation matrix, top level
//   channel  ports               beat
//   in       in_valid/in_ready    in_quat_w/x/y/z, signed Q3.28
//   out      out_valid/out_ready  out_m00..out_m22 signed Q2.30, out_zero_norm
// one quaternion per cycle while out_ready holds; two front stages
// (products, norm and numerators), 32 division cells, one rounding stage.
// every stage has its own valid bit and advances when the next one is empty
// or moving, so bubbles close up under an output stall.
// reset clears the valid bits only.
module quat_to_rotation_matrix import q2r_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_quat_w,
  input  logic signed [31:0] in_quat_x,
  input  logic signed [31:0] in_quat_y,
  input  logic signed [31:0] in_quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_m00,
  output logic signed [31:0] out_m01,
  output logic signed [31:0] out_m02,
  output logic signed [31:0] out_m10,
  output logic signed [31:0] out_m11,
  output logic signed [31:0] out_m12,
  output logic signed [31:0] out_m20,
  output logic signed [31:0] out_m21,
  output logic signed [31:0] out_m22,
  output logic               out_zero_norm
);

  div_t chain_data  [STEPS+1];
  logic chain_valid [STEPS+1];
  logic chain_ready [STEPS+1];
  logic [LANES-1:0][OUT_W-1:0] mat;

  q2r_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (in_valid),
    .ready_out (in_ready),
    .qw        (in_quat_w),
    .qx        (in_quat_x),
    .qy        (in_quat_y),
    .qz        (in_quat_z),
    .valid_out (chain_valid[0]),
    .ready_in  (chain_ready[0]),
    .data_out  (chain_data[0])
  );

  // first cell takes the integer bit without a shift
  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    q2r_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (k != 0),
      .valid_in  (chain_valid[k]),
      .ready_out (chain_ready[k]),
      .data_in   (chain_data[k]),
      .valid_out (chain_valid[k+1]),
      .ready_in  (chain_ready[k+1]),
      .data_out  (chain_data[k+1])
    );
  end

  q2r_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (chain_valid[STEPS]),
    .ready_out (chain_ready[STEPS]),
    .data_in   (chain_data[STEPS]),
    .valid_out (out_valid),
    .ready_in  (out_ready),
    .mat       (mat),
    .zero_norm (out_zero_norm)
  );

  assign out_m00 = mat[0];
  assign out_m01 = mat[1];
  assign out_m02 = mat[2];
  assign out_m10 = mat[3];
  assign out_m11 = mat[4];
  assign out_m12 = mat[5];
  assign out_m20 = mat[6];
  assign out_m21 = mat[7];
  assign out_m22 = mat[8];

endmodule

// ===== tb/sv/quat_to_rotation_matrix_tb.sv =====
// self-checking testbench for the quaternion to rotation matrix block
module quat_to_rotation_matrix_tb import q2r_pkg::*;;

  localparam int N_RANDOM    = 830;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [31:0] NEG_ONE = 32'hC000_0000;

  typedef struct packed {
    logic [8:0][31:0] m;
    logic             zn;
  } matrix_t;

  typedef struct {
    logic [31:0] w, x, y, z;
    bit          typed;
    matrix_t     want;
  } quat_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_quat_w, in_quat_x, in_quat_y, in_quat_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  logic signed [31:0] out_m20, out_m21, out_m22;
  logic               out_zero_norm;

  matrix_t   pending_mats[$];
  quat_row_t dir_rows[$];
  int        mismatches;
  int        cycles;

  quat_to_rotation_matrix DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_quat_w(in_quat_w), .in_quat_x(in_quat_x),
    .in_quat_y(in_quat_y), .in_quat_z(in_quat_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_m00(out_m00), .out_m01(out_m01), .out_m02(out_m02),
    .out_m10(out_m10), .out_m11(out_m11), .out_m12(out_m12),
    .out_m20(out_m20), .out_m21(out_m21), .out_m22(out_m22),
    .out_zero_norm(out_zero_norm)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic matrix_t diag_mat(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                       logic zn);
    matrix_t r;
    r = '0;
    r.m[0] = a;
    r.m[4] = b;
    r.m[8] = c;
    r.zn = zn;
    return r;
  endfunction

  // round(num/den * 2^30) to nearest, ties away from zero
  function automatic logic [31:0] q230_ratio(logic signed [127:0] num, logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    logic         neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag << 31) / den;
    q = (q + 1) >> 1;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic matrix_t rotation_of(logic signed [31:0] qw, logic signed [31:0] qx,
                                          logic signed [31:0] qy, logic signed [31:0] qz);
    logic signed [127:0] w, x, y, z, s;
    logic signed [127:0] num [9];
    matrix_t r;
    w = qw;
    x = qx;
    y = qy;
    z = qz;
    s = w*w + x*x + y*y + z*z;
    if (s == 0) return diag_mat(ONE_Q230, ONE_Q230, ONE_Q230, 1'b1);
    num[0] = w*w + x*x - y*y - z*z;
    num[1] = (x*y - w*z) <<< 1;
    num[2] = (x*z + w*y) <<< 1;
    num[3] = (x*y + w*z) <<< 1;
    num[4] = w*w + y*y - x*x - z*z;
    num[5] = (y*z - w*x) <<< 1;
    num[6] = (x*z - w*y) <<< 1;
    num[7] = (y*z + w*x) <<< 1;
    num[8] = w*w + z*z - x*x - y*y;
    for (int k = 0; k < 9; k++) r.m[k] = q230_ratio(num[k], s);
    r.zn = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] rand_component();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return $urandom_range(0, 255) - 128;
      4: return $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  task automatic add_row(logic [31:0] w, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                         bit typed, matrix_t want);
    quat_row_t r;
    r.w = w;
    r.x = x;
    r.y = y;
    r.z = z;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  // one beat on the input channel, expectation queued on acceptance
  task automatic send_quat(logic [31:0] w, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           bit typed, matrix_t want, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_quat_w <= w;
    in_quat_x <= x;
    in_quat_y <= y;
    in_quat_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_mats.push_back(typed ? want : rotation_of(w, x, y, z));
  endtask

  initial begin
    matrix_t ident;
    matrix_t none;
    logic [31:0] w, x, y, z;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_quat_w = '0;
    in_quat_x = '0;
    in_quat_y = '0;
    in_quat_z = '0;
    mismatches = 0;
    ident = diag_mat(ONE_Q230, ONE_Q230, ONE_Q230, 1'b0);
    none = '0;
    add_row(0, 0, 0, 0, 1'b1, diag_mat(ONE_Q230, ONE_Q230, ONE_Q230, 1'b1));
    add_row(32'h1000_0000, 0, 0, 0, 1'b1, ident);
    add_row(32'h8000_0000, 0, 0, 0, 1'b1, ident);
    add_row(32'h7FFF_FFFF, 0, 0, 0, 1'b1, ident);
    add_row(1, 0, 0, 0, 1'b1, ident);
    add_row(0, 32'h7FFF_FFFF, 0, 0, 1'b1, diag_mat(ONE_Q230, NEG_ONE, NEG_ONE, 1'b0));
    add_row(0, 32'h8000_0000, 0, 0, 1'b1, diag_mat(ONE_Q230, NEG_ONE, NEG_ONE, 1'b0));
    add_row(0, 0, 1, 0, 1'b1, diag_mat(NEG_ONE, ONE_Q230, NEG_ONE, 1'b0));
    add_row(0, 0, 0, 32'h8000_0000, 1'b1, diag_mat(NEG_ONE, NEG_ONE, ONE_Q230, 1'b0));
    add_row(0, 0, 0, 32'hFFFF_FFFF, 1'b1, diag_mat(NEG_ONE, NEG_ONE, ONE_Q230, 1'b0));
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, none);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, none);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, none);
    add_row(32'h1000_0000, 32'h1000_0000, 0, 0, 1'b0, none);
    add_row(32'h1000_0000, 0, 32'hF000_0000, 0, 1'b0, none);
    add_row(32'h1000_0000, 0, 0, 32'h1000_0000, 1'b0, none);
    add_row(1, 1, 1, 1, 1'b0, none);
    add_row(1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1'b0, none);
    add_row(3, 1, 0, 0, 1'b0, none);
    add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC, 1'b0, none);
    add_row(32'h0000_0007, 32'h7FFF_FFFF, 32'h0000_0003, 32'h8000_0001, 1'b0, none);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i])
      send_quat(dir_rows[i].w, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                dir_rows[i].typed, dir_rows[i].want, gap_len());
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 500) begin
        // drain everything before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_mats.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 29) == 0) begin
        w = 0; x = 0; y = 0; z = 0;
      end else begin
        w = rand_component();
        x = rand_component();
        y = rand_component();
        z = rand_component();
      end
      send_quat(w, x, y, z, 1'b0, none, (n >= 600 && n < 720) ? 0 : gap_len());
    end
    in_valid <= 1'b0;
    while (pending_mats.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_mats.size() == 0)
      $display("quat_to_rotation_matrix_tb: done, clean");
    else
      $display("quat_to_rotation_matrix_tb: done, errors");
    $finish;
  end

  // receiver side: random stalls, one long hold-off so the pipe backs up
  initial begin
    int hold;
    int rcv_cycles;
    bit held;
    out_ready = 1'b0;
    held = 1'b0;
    rcv_cycles = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && rcv_cycles > 1500) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        rcv_cycles += 300;
      end
      out_ready <= 1'b1;
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      repeat (hold) @(posedge clk);
      rcv_cycles += hold;
      hold = gap_len();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
        rcv_cycles += hold;
      end
    end
  end

  always @(posedge clk) begin
    matrix_t got;
    matrix_t want;
    if (rst_n && out_valid && out_ready) begin
      got.m = {out_m22, out_m21, out_m20, out_m12, out_m11, out_m10, out_m02, out_m01, out_m00};
      got.zn = out_zero_norm;
      if (pending_mats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %h", got);
      end else begin
        want = pending_mats.pop_front();
        for (int k = 0; k < 9; k++)
          if (got.m[k] !== want.m[k]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("m%0d%0d mismatch: expected %h, got %h", k / 3, k % 3,
                       want.m[k], got.m[k]);
          end
        if (got.zn !== want.zn) begin
          mismatches++;
          if (mismatches <= 10)
            $display("zero_norm mismatch: expected %b, got %b", want.zn, got.zn);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("quat_to_rotation_matrix_tb: done, errors");
      $finish;
    end
  end

  initial cycles = 0;

endmodule
